[sv/tsps_pkg.sv]
// ----------------------------------------------------------------------------
// tsps_pkg: shared types and constants of the two-sensor pass sequencer
// Holds the sensor and request codes, the register indexes and the structs
// that carry configuration, sequencer state and one result between modules.
// ----------------------------------------------------------------------------
package tsps_pkg;

    localparam int SENSOR_COUNT = 2;
    localparam int TIME_BITS    = 32;
    localparam int IDX_BITS     = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int CUR_BITS     = $clog2(SENSOR_COUNT + 1);
    localparam int DIST_BITS    = 16;
    localparam int HIT_BITS     = 8;
    localparam int NOW_BITS     = 32;

    // Sensor states.
    localparam logic [1:0] ST_WAIT   = 2'd0;
    localparam logic [1:0] ST_ACTIVE = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;

    // Request kinds.
    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_NOTICE  = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    // Configuration register indexes.
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_TRIGGER   = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_CLAMP     = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_HITS      = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_DELAY     = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_TIMEOUT   = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_FIRST     = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_HAS_NEXT  = 3'd6;

    localparam logic [CUR_BITS-1:0] CUR_NONE = CUR_BITS'(SENSOR_COUNT);
    localparam logic [HIT_BITS-1:0] HIT_MAX  = {HIT_BITS{1'b1}};

    typedef struct packed {
        logic [DIST_BITS-1:0] trigger_level;
        logic [DIST_BITS-1:0] clamp_level;
        logic [HIT_BITS-1:0]  hits_needed;
        logic [15:0]          arm_delay;
        logic [31:0]          idle_timeout;
        logic                 is_first_stage;
        logic                 has_next_stage;
    } t_cfg;

    typedef struct packed {
        logic [SENSOR_COUNT-1:0][1:0]         status;
        logic [SENSOR_COUNT-1:0][HIT_BITS-1:0] hits;
        logic [CUR_BITS-1:0]                  cur;
        logic                                 pend;
        logic [IDX_BITS-1:0]                  pend_idx;
        logic [TIME_BITS-1:0]                 pend_due;
        logic [TIME_BITS-1:0]                 last_act;
    } t_state;

    typedef struct packed {
        logic [1:0]           active_index;
        logic [1:0]           first_state;
        logic [1:0]           second_state;
        logic [DIST_BITS-1:0] shown_distance;
        logic                 did_activate;
        logic                 did_confirm;
        logic                 group_done;
        logic                 track_done;
        logic                 did_reset;
    } t_result;

endpackage

[sv/tsps_step.sv]
// ----------------------------------------------------------------------------
// tsps_step: next-state and result logic for one request
// Takes the current sequencer state and one request and returns the state
// after it together with the result it produces.
// ----------------------------------------------------------------------------
module tsps_step (
    input  tsps_pkg::t_cfg                    i_cfg,
    input  tsps_pkg::t_state                  i_state,
    input  logic [1:0]                        i_req_type,
    input  logic [tsps_pkg::NOW_BITS-1:0]     i_now_ms,
    input  logic [tsps_pkg::DIST_BITS-1:0]    i_distance,
    output tsps_pkg::t_state                  o_state,
    output tsps_pkg::t_result                 o_result
);

    tsps_pkg::t_state                     st;
    logic [tsps_pkg::TIME_BITS-1:0]       now;
    logic [tsps_pkg::TIME_BITS-1:0]       due_diff;
    logic [tsps_pkg::TIME_BITS-1:0]       idle_diff;
    logic [tsps_pkg::TIME_BITS-1:0]       due_new;
    logic [tsps_pkg::IDX_BITS-1:0]        idx;
    logic [tsps_pkg::DIST_BITS-1:0]       dist_c;
    logic [tsps_pkg::HIT_BITS-1:0]        h;
    logic [tsps_pkg::DIST_BITS-1:0]       shown;
    logic act, conf, grp, trk, rst;

    assign now     = tsps_pkg::TIME_BITS'(i_now_ms);
    assign due_new = now + tsps_pkg::TIME_BITS'(i_cfg.arm_delay);
    assign dist_c  = (i_distance > i_cfg.clamp_level) ? i_cfg.clamp_level : i_distance;

    always_comb begin
        st        = i_state;
        act       = 1'b0;
        conf      = 1'b0;
        grp       = 1'b0;
        trk       = 1'b0;
        rst       = 1'b0;
        shown     = '0;
        idx       = '0;
        h         = '0;
        due_diff  = now - i_state.pend_due;
        idle_diff = '0;

        case (i_req_type)
            tsps_pkg::REQ_TICK: begin
                // A pending activation fires once its due time is not in the future.
                if (st.pend && !due_diff[tsps_pkg::TIME_BITS-1]) begin
                    st.pend               = 1'b0;
                    st.status[st.pend_idx] = tsps_pkg::ST_ACTIVE;
                    st.hits[st.pend_idx]   = '0;
                    st.cur                = tsps_pkg::CUR_BITS'(st.pend_idx);
                    st.last_act           = now;
                    act                   = 1'b1;
                end
                idle_diff = now - st.last_act;
                if (st.cur < tsps_pkg::CUR_NONE &&
                    idle_diff >= tsps_pkg::TIME_BITS'(i_cfg.idle_timeout)) begin
                    rst = 1'b1;
                end else if (st.cur < tsps_pkg::CUR_NONE) begin
                    idx   = st.cur[tsps_pkg::IDX_BITS-1:0];
                    shown = dist_c;
                    h     = st.hits[idx];
                    if (dist_c <= i_cfg.trigger_level) begin
                        if (h != tsps_pkg::HIT_MAX) begin
                            h = h + 1'b1;
                        end
                        st.last_act = now;
                    end else begin
                        h = '0;
                    end
                    st.hits[idx] = h;
                    if (h >= i_cfg.hits_needed) begin
                        conf            = 1'b1;
                        st.cur          = tsps_pkg::CUR_NONE;
                        st.status[idx]  = tsps_pkg::ST_DONE;
                        if (int'(idx) < tsps_pkg::SENSOR_COUNT - 1 &&
                            st.status[idx + 1'b1] == tsps_pkg::ST_WAIT) begin
                            st.pend     = 1'b1;
                            st.pend_idx = idx + 1'b1;
                            st.pend_due = due_new;
                        end else if (i_cfg.has_next_stage) begin
                            grp = 1'b1;
                        end else begin
                            trk = 1'b1;
                        end
                    end
                end
            end
            tsps_pkg::REQ_NOTICE: begin
                if (!i_cfg.is_first_stage) begin
                    st.pend     = 1'b1;
                    st.pend_idx = '0;
                    st.pend_due = due_new;
                end
            end
            tsps_pkg::REQ_RESTART: begin
                rst = 1'b1;
            end
            default: begin
            end
        endcase

        // Full clear, shared by the idle timeout and the restart request.
        if (rst) begin
            st.cur      = tsps_pkg::CUR_NONE;
            st.pend     = 1'b0;
            st.status   = '0;
            st.hits     = '0;
            st.last_act = now;
            if (i_cfg.is_first_stage) begin
                st.status[0] = tsps_pkg::ST_ACTIVE;
                st.cur       = '0;
                act          = 1'b1;
            end
        end
    end

    assign o_state = st;

    always_comb begin
        o_result.active_index   = 2'(st.cur);
        o_result.first_state    = st.status[0];
        o_result.second_state   = (tsps_pkg::SENSOR_COUNT > 1) ?
                                  st.status[tsps_pkg::SENSOR_COUNT - 1] : 2'd0;
        o_result.shown_distance = shown;
        o_result.did_activate   = act;
        o_result.did_confirm    = conf;
        o_result.group_done     = grp;
        o_result.track_done     = trk;
        o_result.did_reset      = rst;
    end

endmodule

[sv/two_sensor_pass_sequencer.sv]
// ----------------------------------------------------------------------------
// two_sensor_pass_sequencer: sequencing of two distance sensors on a pass
// Accepts ticks, upstream notices and restarts and returns one result per
// request with the sensor states and the events of that step.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s         in         i_s_tvalid/o_s_tready  tuser req_type, tdata now, dist
//  m         out        o_m_tvalid/i_m_tready  tdata sensor states and events
//  cfg       in         i_cfg_we               i_cfg_addr, i_cfg_wdata
//
// One transaction per cycle: the request is decoded and the state updated in
// the cycle it is accepted, and its result appears in the output register on
// the next cycle. The output register stalls only the input while it is full
// and not taken. Synchronous active-low reset restores the register defaults,
// clears all sensors and leaves no sensor active.
// ----------------------------------------------------------------------------
module two_sensor_pass_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [31:0] now_ms, [47:32] distance
    input  logic [47:0] i_s_tdata,
    // [1:0] req_type
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [1:0] active_index, [3:2] first_state, [5:4] second_state,
    // [21:6] shown_distance, [22] did_activate, [23] did_confirm,
    // [24] group_done, [25] track_done, [26] did_reset, [31:27] zero
    output logic [31:0] o_m_tdata,
    input  logic        i_cfg_we,
    input  logic [tsps_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [tsps_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata
);

    tsps_pkg::t_cfg    r_cfg;
    tsps_pkg::t_state  r_state;
    tsps_pkg::t_state  n_state;
    tsps_pkg::t_result r_out;
    tsps_pkg::t_result n_out;
    logic              r_out_valid;
    logic              s_accept;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    tsps_step u_step (
        .i_cfg      (r_cfg),
        .i_state    (r_state),
        .i_req_type (i_s_tuser),
        .i_now_ms   (i_s_tdata[31:0]),
        .i_distance (i_s_tdata[47:32]),
        .o_state    (n_state),
        .o_result   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_level    <= 16'd100;
            r_cfg.clamp_level      <= 16'd200;
            r_cfg.hits_needed      <= 8'd5;
            r_cfg.arm_delay        <= 16'd800;
            r_cfg.idle_timeout     <= 32'd15000;
            r_cfg.is_first_stage   <= 1'b1;
            r_cfg.has_next_stage   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tsps_pkg::CFG_TRIGGER:  r_cfg.trigger_level    <= i_cfg_wdata[15:0];
                tsps_pkg::CFG_CLAMP:    r_cfg.clamp_level      <= i_cfg_wdata[15:0];
                tsps_pkg::CFG_HITS:     r_cfg.hits_needed      <= i_cfg_wdata[7:0];
                tsps_pkg::CFG_DELAY:    r_cfg.arm_delay        <= i_cfg_wdata[15:0];
                tsps_pkg::CFG_TIMEOUT:  r_cfg.idle_timeout     <= i_cfg_wdata[31:0];
                tsps_pkg::CFG_FIRST:    r_cfg.is_first_stage   <= i_cfg_wdata[0];
                tsps_pkg::CFG_HAS_NEXT: r_cfg.has_next_stage   <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.status   <= '0;
            r_state.hits     <= '0;
            r_state.cur      <= tsps_pkg::CUR_NONE;
            r_state.pend     <= 1'b0;
            r_state.pend_idx <= '0;
            r_state.pend_due <= '0;
            r_state.last_act <= '0;
            r_out_valid      <= 1'b0;
        end else if (s_accept) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out.did_reset, r_out.track_done, r_out.group_done,
                         r_out.did_confirm, r_out.did_activate, r_out.shown_distance,
                         r_out.second_state, r_out.first_state, r_out.active_index};

endmodule

[tb/tb_two_sensor_pass_sequencer.sv]
// ----------------------------------------------------------------------------
// tb_two_sensor_pass_sequencer: self-checking bench for the pass sequencer
// Requests go in through a queue-fed stream driver, and every result is
// checked against an in-bench model of the sequencer. The model keeps its own
// sensor states, hit counters, pending activation and register copy. The run
// steps through several register settings, including the extremes. Each
// setting gets a directed or random mix of ticks, notices and restarts;
// all but the last two add random idle cycles on both stream sides.
// ----------------------------------------------------------------------------
module tb_two_sensor_pass_sequencer;

    import tsps_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now;
        logic [15:0] reading;
    } pass_req_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [47:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic        i_cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata = '0;

    two_sensor_pass_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // Register copy and sequencer state of the model.
    t_cfg        seq_cfg;
    logic [1:0]  sensor_st [SENSOR_COUNT];
    logic [7:0]  hit_cnt [SENSOR_COUNT];
    logic [1:0]  cur_sensor;
    logic        pend_on;
    logic        pend_sel;
    logic [31:0] pend_due;
    logic [31:0] last_hit_ms;

    pass_req_t request_fifo[$];
    t_result   report_fifo[$];
    pass_req_t next_req;
    t_result   got;
    t_result   want;
    int        fail_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    logic [31:0] clk_ms;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic void activate_sensor(logic [1:0] idx, logic [31:0] now);
        sensor_st[idx[0]] = ST_ACTIVE;
        hit_cnt[idx[0]]   = '0;
        cur_sensor        = idx;
        last_hit_ms       = now;
    endfunction

    // Clears all sensors; returns 1 when a first stage restarts sensor 0.
    function automatic logic clear_sensors(logic [31:0] now);
        cur_sensor  = CUR_NONE;
        pend_on     = 1'b0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            sensor_st[i] = ST_WAIT;
            hit_cnt[i]   = '0;
        end
        last_hit_ms = now;
        if (seq_cfg.is_first_stage) begin
            activate_sensor(2'd0, now);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_result sequence_request(pass_req_t req);
        t_result     res;
        logic [31:0] since_due;
        logic [31:0] idle_ms;
        logic [15:0] d;
        logic [1:0]  idx;
        logic [1:0]  nxt;
        res = '0;
        if (req.kind == REQ_TICK) begin
            since_due = req.now - pend_due;
            if (pend_on && !since_due[31]) begin
                pend_on = 1'b0;
                activate_sensor({1'b0, pend_sel}, req.now);
                res.did_activate = 1'b1;
            end
            idle_ms = req.now - last_hit_ms;
            if (cur_sensor < SENSOR_COUNT && idle_ms >= seq_cfg.idle_timeout) begin
                if (clear_sensors(req.now)) res.did_activate = 1'b1;
                res.did_reset = 1'b1;
            end else if (cur_sensor < SENSOR_COUNT) begin
                idx = cur_sensor;
                d = (req.reading > seq_cfg.clamp_level) ? seq_cfg.clamp_level : req.reading;
                res.shown_distance = d;
                if (d <= seq_cfg.trigger_level) begin
                    if (hit_cnt[idx[0]] < HIT_MAX) hit_cnt[idx[0]]++;
                    last_hit_ms = req.now;
                end else begin
                    hit_cnt[idx[0]] = '0;
                end
                if (hit_cnt[idx[0]] >= seq_cfg.hits_needed) begin
                    nxt = idx + 2'd1;
                    res.did_confirm = 1'b1;
                    cur_sensor = CUR_NONE;
                    sensor_st[idx[0]] = ST_DONE;
                    if (nxt < SENSOR_COUNT && sensor_st[nxt[0]] == ST_WAIT) begin
                        pend_on  = 1'b1;
                        pend_sel = nxt[0];
                        pend_due = req.now + 32'(seq_cfg.arm_delay);
                    end else if (seq_cfg.has_next_stage) begin
                        res.group_done = 1'b1;
                    end else begin
                        res.track_done = 1'b1;
                    end
                end
            end
        end else if (req.kind == REQ_NOTICE) begin
            if (!seq_cfg.is_first_stage) begin
                pend_on  = 1'b1;
                pend_sel = 1'b0;
                pend_due = req.now + 32'(seq_cfg.arm_delay);
            end
        end else if (req.kind == REQ_RESTART) begin
            if (clear_sensors(req.now)) res.did_activate = 1'b1;
            res.did_reset = 1'b1;
        end
        res.active_index = cur_sensor;
        res.first_state  = sensor_st[0];
        res.second_state = sensor_st[1];
        return res;
    endfunction

    // Stream driver: a new request is presented once the current one is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                report_fifo.push_back(sequence_request({i_s_tuser, i_s_tdata[31:0],
                                                        i_s_tdata[47:32]}));
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (request_fifo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_req = request_fifo.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tuser  <= next_req.kind;
                    i_s_tdata  <= {next_req.reading, next_req.now};
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.active_index   = o_m_tdata[1:0];
                got.first_state    = o_m_tdata[3:2];
                got.second_state   = o_m_tdata[5:4];
                got.shown_distance = o_m_tdata[21:6];
                got.did_activate   = o_m_tdata[22];
                got.did_confirm    = o_m_tdata[23];
                got.group_done     = o_m_tdata[24];
                got.track_done     = o_m_tdata[25];
                got.did_reset      = o_m_tdata[26];
                if (report_fifo.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transaction: %h", o_m_tdata);
                end else begin
                    want = report_fifo.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: expected cur=%0d st0=%0d st1=%0d dist=%0d %s%b%b%b%b%b",
                                     want.active_index, want.first_state,
                                     want.second_state, want.shown_distance,
                                     "act/conf/grp/trk/rst=",
                                     want.did_activate, want.did_confirm, want.group_done,
                                     want.track_done, want.did_reset);
                            $display("          actual   cur=%0d st0=%0d st1=%0d dist=%0d %s%b%b%b%b%b",
                                     got.active_index, got.first_state, got.second_state,
                                     got.shown_distance, "act/conf/grp/trk/rst=",
                                     got.did_activate, got.did_confirm,
                                     got.group_done, got.track_done, got.did_reset);
                        end
                    end
                end
            end
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic push_req(logic [1:0] kind, logic [31:0] now, logic [15:0] reading);
        request_fifo.push_back('{kind: kind, now: now, reading: reading});
    endtask

    task automatic write_reg(logic [CFG_ADDR_BITS-1:0] addr, logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        case (addr)
            CFG_TRIGGER:  seq_cfg.trigger_level    = value[15:0];
            CFG_CLAMP:    seq_cfg.clamp_level      = value[15:0];
            CFG_HITS:     seq_cfg.hits_needed      = value[7:0];
            CFG_DELAY:    seq_cfg.arm_delay        = value[15:0];
            CFG_TIMEOUT:  seq_cfg.idle_timeout     = value;
            CFG_FIRST:    seq_cfg.is_first_stage   = value[0];
            CFG_HAS_NEXT: seq_cfg.has_next_stage   = value[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [15:0] trig, logic [15:0] clamp, logic [7:0] hits,
                                  logic [15:0] delay, logic [31:0] tmo, logic first,
                                  logic next_stage);
        write_reg(CFG_TRIGGER, 32'(trig));
        write_reg(CFG_CLAMP, 32'(clamp));
        write_reg(CFG_HITS, 32'(hits));
        write_reg(CFG_DELAY, 32'(delay));
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_FIRST, 32'(first));
        write_reg(CFG_HAS_NEXT, 32'(next_stage));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every request has been taken and every result checked.
    task automatic drain();
        for (int k = 0; k < 200000; k++) begin
            if (request_fifo.size() == 0 && !i_s_tvalid && report_fifo.size() == 0) break;
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly well-formed passes with small time steps, mixed with restarts,
    // notices, time jumps across the timeout or the wrap, and stray readings.
    task automatic gen_random(int count);
        int          roll;
        logic [1:0]  kind;
        logic [15:0] reading;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) kind = REQ_RESTART;
            else if (roll < 6) kind = REQ_NOTICE;
            else if (roll < 7) kind = REQ_UNUSED;
            else if (!seq_cfg.is_first_stage && roll < 12) kind = REQ_NOTICE;
            else kind = REQ_TICK;
            roll = $urandom_range(0, 99);
            if (roll < 3) clk_ms = $urandom;
            else if (roll < 6) clk_ms += seq_cfg.idle_timeout + $urandom_range(0, 2) - 1;
            else if (roll < 10) clk_ms += 32'(seq_cfg.arm_delay) + $urandom_range(0, 1);
            else clk_ms += $urandom_range(0, 250);
            roll = $urandom_range(0, 99);
            if (roll < 65) reading = 16'($urandom_range(0, seq_cfg.trigger_level));
            else if (roll < 70) reading = seq_cfg.trigger_level;
            else if (roll < 75) reading = seq_cfg.clamp_level;
            else if (roll < 90) reading = 16'($urandom_range(0, 65535));
            else if (roll < 95) reading = 16'hFFFF;
            else reading = seq_cfg.trigger_level + 16'd1;
            push_req(kind, clk_ms, reading);
        end
    endtask

    initial begin
        seq_cfg = '{trigger_level: 16'd100, clamp_level: 16'd200, hits_needed: 8'd5,
                    arm_delay: 16'd800, idle_timeout: 32'd15000,
                    is_first_stage: 1'b1, has_next_stage: 1'b1};
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            sensor_st[i] = ST_WAIT;
            hit_cnt[i]   = '0;
        end
        cur_sensor  = CUR_NONE;
        pend_on     = 1'b0;
        pend_sel    = 1'b0;
        pend_due    = '0;
        last_hit_ms = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values; sender idles a little, receiver a lot.
        send_idle_pct = 7;
        recv_idle_pct = 86;
        push_req(REQ_TICK, 32'd500, 16'd0);          // nothing active after reset
        push_req(REQ_NOTICE, 32'd600, 16'd0);        // ignored in a first stage
        push_req(REQ_UNUSED, 32'd700, 16'hFFFF);
        push_req(REQ_RESTART, 32'd1000, 16'd0);
        push_req(REQ_TICK, 32'd1010, 16'hFFFF);      // clamped, a miss
        push_req(REQ_TICK, 32'd1020, 16'd100);       // exactly at the trigger level
        push_req(REQ_TICK, 32'd1030, 16'd101);       // miss clears the count
        push_req(REQ_TICK, 32'd1040, 16'd0);
        push_req(REQ_TICK, 32'd1050, 16'd100);
        push_req(REQ_TICK, 32'd1060, 16'd50);
        push_req(REQ_TICK, 32'd1070, 16'd0);
        push_req(REQ_TICK, 32'd1080, 16'd99);        // confirms sensor 0
        push_req(REQ_TICK, 32'd1879, 16'd0);         // one before the activation
        push_req(REQ_TICK, 32'd1880, 16'd0);         // activation and first hit
        for (int i = 1; i <= 4; i++)
            push_req(REQ_TICK, 32'd1880 + 32'(10 * i), 16'd0);
        push_req(REQ_TICK, 32'd1930, 16'd0);
        push_req(REQ_RESTART, 32'hFFFF_FF00, 16'd0);
        push_req(REQ_TICK, 32'hFFFF_FF00 + 32'd14999, 16'd300);
        push_req(REQ_TICK, 32'hFFFF_FF00 + 32'd15000, 16'd300);  // timeout across the wrap
        clk_ms = 32'hFFFF_FF00 + 32'd15010;
        gen_random(220);
        drain();

        apply_settings(16'd100, 16'd200, 8'd3, 16'd50, 32'd2000, 1'b1, 1'b0);
        gen_random(240);
        drain();

        send_idle_pct = 86;
        recv_idle_pct = 7;
        apply_settings(16'hFFFF, 16'hFFFF, 8'd255, 16'd0, 32'hFFFF_FFFF, 1'b0, 1'b1);
        gen_random(240);
        drain();

        apply_settings(16'd0, 16'd0, 8'd1, 16'hFFFF, 32'd0, 1'b1, 1'b1);
        gen_random(240);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_settings(16'd500, 16'd300, 8'd0, 16'd10, 32'd500, 1'b0, 1'b0);
        gen_random(240);
        drain();

        apply_settings(16'd150, 16'd65535, 8'd2, 16'd1000, 32'd3000, 1'b1, 1'b1);
        gen_random(250);
        drain();

        if (fail_count == 0 && report_fifo.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
